// ----- design/ecpdm_pkg.sv -----
package ecpdm_pkg;

  localparam int unsigned REF_PERIOD_DEF = 2000;
  localparam int unsigned PER_MILLE      = 1000;

  // widths fixed by the item format
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CAP_W   = 11;
  // per-mille numerator: 32-bit high time times 1000
  localparam int unsigned NUM_W   = 42;
  // quotient never exceeds 1000, so 11 quotient bits
  localparam int unsigned QUOT_W  = 11;
  localparam int unsigned QCNT_W  = 4;

  localparam logic [1:0] OP_START_PERIOD = 2'd0;
  localparam logic [1:0] OP_START_DUTY   = 2'd1;
  localparam logic [1:0] OP_TICK         = 2'd2;
  localparam logic [1:0] OP_EDGE         = 2'd3;

  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_TIMEOUT = 2'd1;
  localparam logic [1:0] STS_ERROR   = 2'd2;

  typedef enum logic [2:0] {
    G_IDLE,
    G_OPENING,
    G_OPEN,
    G_DUTY_H1,
    G_DUTY_LO,
    G_DUTY_H2
  } gate_t;

  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_DECODE,
    SQ_STAMP,
    SQ_EDGE,
    SQ_CHK_OPEN,
    SQ_CHK_MID,
    SQ_CHK_HIGH,
    SQ_MUL,
    SQ_DIV,
    SQ_EMIT
  } seq_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               duty_mode;
    logic [STAMP_W-1:0] value;
  } res_t;

endpackage

// ----- design/ecpdm_alu.sv -----
// shared subtract / compare unit: all stamp checks and every divide step
module ecpdm_alu
  import ecpdm_pkg::*;
(
  input  logic [NUM_W-1:0] a,
  input  logic [NUM_W-1:0] b,
  output logic [NUM_W-1:0] diff,
  output logic             borrow
);

  logic [NUM_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[NUM_W-1:0];
  assign borrow = full[NUM_W];

endmodule

// ----- design/ecpdm_out.sv -----
// output register: holds one result item until the receiver takes it
module ecpdm_out
  import ecpdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // value
  output logic [2:0]  m_tuser   // status[1:0], duty_mode[2]
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= res.value;
      m_tuser <= {res.duty_mode, res.status};
    end
  end

endmodule

// ----- design/edge_capture_period_duty_meter_core.sv -----
// Period / duty meter gated by a reference timer that wraps every REF_PERIOD.
//
// Input channel s_*: one item per handshake; tuser carries the opcode (start
// period, start duty, reference tick, signal edge), tdata carries edge_target,
// timeout_ms and capture_value. Output channel m_*: at most one result item
// per input item; tuser carries status and duty_mode, tdata the value.
//
// Items are handled one at a time by a sequencer around one shared 42-bit
// subtractor. s_tready is high only while the sequencer is idle. Start and
// tick items and edges on an idle gate only pass the decode state; other
// edges also pass the stamp and edge states, a period close adds one stamp
// compare, and a duty close adds three stamp compares, one multiply and an
// 11-step restoring divide for the per-mille value. A result is then loaded
// into the output register from the emit state.
//
// The output register lets the next item be taken while a result waits. If the
// receiver stalls with a result still held, a new result waits in the
// sequencer and input is held off until the register frees.
//
// Reset (synchronous, rst high) returns the gate to idle, clears the counters
// and stamps and empties the output register.
module edge_capture_period_duty_meter_core
  import ecpdm_pkg::*;
#(
  parameter int unsigned REF_PERIOD = REF_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // edge_target[31:0], timeout_ms[47:32], capture_value[58:48]
  input  logic [1:0]  s_tuser,  // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // value[31:0]
  output logic [2:0]  m_tuser   // status[1:0], duty_mode[2]
);

  localparam logic [TICK_W-1:0]  RP      = TICK_W'(REF_PERIOD);
  localparam logic [TICK_W-1:0]  SAT_MAX = {TICK_W{1'b1}};
  localparam logic [QUOT_W-1:0]  QMAX    = QUOT_W'(PER_MILLE);
  localparam logic [QCNT_W-1:0]  QLAST   = QCNT_W'(QUOT_W - 1);

  seq_t seq, seq_next;
  gate_t gate;

  logic [1:0]         op;
  logic [STAMP_W-1:0] target;
  logic [TICK_W-1:0]  tmo;
  logic [CAP_W-1:0]   cap;

  logic [TICK_W-1:0]  wrap_count;
  logic [STAMP_W-1:0] edges_left;
  logic [STAMP_W-1:0] open_stamp;
  logic [STAMP_W-1:0] mid_stamp;
  logic [TICK_W-1:0]  elapsed_ms;
  logic [TICK_W-1:0]  timeout_limit;

  logic [STAMP_W-1:0] prod;
  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] period;
  logic [STAMP_W-1:0] high;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   den;
  logic [QUOT_W-1:0]  quot;
  logic [QCNT_W-1:0]  qcnt;
  res_t               res;

  logic [NUM_W-1:0]   alu_a, alu_b, alu_diff;
  logic               alu_borrow;
  logic               out_load, out_free;

  logic [TICK_W-1:0]  el_inc;
  logic [STAMP_W-1:0] edges_dec;
  logic [QUOT_W-1:0]  quot_step;
  logic               duty_active;
  logic               tick_expire;

  assign el_inc      = (elapsed_ms != SAT_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;
  assign tick_expire = (gate != G_IDLE) && (el_inc >= timeout_limit);
  assign edges_dec   = edges_left - 1'b1;
  assign quot_step   = {quot[QUOT_W-2:0], ~alu_borrow};
  assign duty_active = (gate == G_DUTY_H1) || (gate == G_DUTY_LO) || (gate == G_DUTY_H2);

  ecpdm_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  ecpdm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (res),
    .can_load (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  always_comb begin
    seq_next = seq;
    s_tready = 1'b0;
    out_load = 1'b0;
    alu_a    = '0;
    alu_b    = '0;
    unique case (seq)
      SQ_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) seq_next = SQ_DECODE;
      end
      SQ_DECODE: begin
        unique case (op) inside
          OP_START_PERIOD, OP_START_DUTY: begin
            seq_next = (tmo == '0) ? SQ_EMIT : SQ_IDLE;
          end
          OP_TICK: begin
            seq_next = tick_expire ? SQ_EMIT : SQ_IDLE;
          end
          default: begin
            seq_next = (gate == G_IDLE) ? SQ_IDLE : SQ_STAMP;
          end
        endcase
      end
      SQ_STAMP: seq_next = SQ_EDGE;
      SQ_EDGE: begin
        unique case (gate)
          G_OPEN:    seq_next = (edges_dec != '0) ? SQ_IDLE : SQ_CHK_OPEN;
          G_DUTY_H2: seq_next = SQ_CHK_OPEN;
          default:   seq_next = SQ_IDLE;
        endcase
      end
      SQ_CHK_OPEN: begin
        alu_a = NUM_W'(stamp);
        alu_b = NUM_W'(open_stamp);
        if (alu_borrow || gate == G_OPEN || alu_diff == '0) begin
          seq_next = SQ_EMIT;
        end else begin
          seq_next = SQ_CHK_MID;
        end
      end
      SQ_CHK_MID: begin
        alu_a = NUM_W'(mid_stamp);
        alu_b = NUM_W'(open_stamp);
        seq_next = alu_borrow ? SQ_EMIT : SQ_CHK_HIGH;
      end
      SQ_CHK_HIGH: begin
        alu_a = NUM_W'(stamp);
        alu_b = NUM_W'(mid_stamp);
        seq_next = alu_borrow ? SQ_EMIT : SQ_MUL;
      end
      SQ_MUL: seq_next = SQ_DIV;
      SQ_DIV: begin
        alu_a = num;
        alu_b = den;
        if (qcnt == '0) seq_next = SQ_EMIT;
      end
      SQ_EMIT: begin
        out_load = out_free;
        if (out_free) seq_next = SQ_IDLE;
      end
      default: seq_next = SQ_IDLE;
    endcase
  end

  // gate state and counters follow the measurement rules
  always_ff @(posedge clk) begin
    if (rst) begin
      gate          <= G_IDLE;
      wrap_count    <= '0;
      edges_left    <= '0;
      open_stamp    <= '0;
      mid_stamp     <= '0;
      elapsed_ms    <= '0;
      timeout_limit <= '0;
    end else begin
      unique case (seq)
        SQ_DECODE: begin
          unique case (op) inside
            OP_START_PERIOD, OP_START_DUTY: begin
              wrap_count    <= '0;
              elapsed_ms    <= '0;
              timeout_limit <= tmo;
              edges_left    <= target;
              if (tmo == '0) begin
                gate <= G_IDLE;
              end else begin
                gate <= (op == OP_START_PERIOD) ? G_OPENING : G_DUTY_H1;
              end
            end
            OP_TICK: begin
              wrap_count <= wrap_count + 1'b1;
              if (gate != G_IDLE) begin
                elapsed_ms <= el_inc;
                if (tick_expire) gate <= G_IDLE;
              end
            end
            default: ;
          endcase
        end
        SQ_EDGE: begin
          unique case (gate)
            G_OPENING: begin
              open_stamp <= stamp;
              gate       <= G_OPEN;
            end
            G_OPEN:    edges_left <= edges_dec;
            G_DUTY_H1: begin
              open_stamp <= stamp;
              gate       <= G_DUTY_LO;
            end
            G_DUTY_LO: begin
              mid_stamp <= stamp;
              gate      <= G_DUTY_H2;
            end
            G_DUTY_H2: ;
            default:   gate <= G_IDLE;
          endcase
        end
        SQ_EMIT: gate <= G_IDLE;
        default: ;
      endcase
    end
  end

  // datapath: latched item, stamp, checks and divider
  always_ff @(posedge clk) begin
    if (seq == SQ_IDLE && s_tvalid) begin
      op     <= s_tuser;
      target <= s_tdata[31:0];
      tmo    <= s_tdata[47:32];
      cap    <= s_tdata[58:48];
    end
    unique case (seq)
      SQ_DECODE: begin
        prod <= {{(STAMP_W-TICK_W){1'b0}}, wrap_count} * {{(STAMP_W-TICK_W){1'b0}}, RP};
        if (op == OP_START_PERIOD || op == OP_START_DUTY) begin
          res <= '{status: STS_TIMEOUT, duty_mode: op[0], value: '0};
        end else begin
          res <= '{status: STS_TIMEOUT, duty_mode: duty_active, value: '0};
        end
      end
      SQ_STAMP: stamp <= prod + STAMP_W'(cap);
      SQ_CHK_OPEN: begin
        period <= alu_diff[STAMP_W-1:0];
        if (alu_borrow) begin
          res <= '{status: STS_ERROR, duty_mode: (gate == G_DUTY_H2), value: '0};
        end else if (gate == G_OPEN) begin
          res <= '{status: STS_DONE, duty_mode: 1'b0, value: alu_diff[STAMP_W-1:0]};
        end else begin
          // zero period
          res <= '{status: STS_ERROR, duty_mode: 1'b1, value: '0};
        end
      end
      SQ_CHK_MID: begin
        high <= alu_diff[STAMP_W-1:0];
        res  <= '{status: STS_ERROR, duty_mode: 1'b1, value: '0};
      end
      SQ_MUL: begin
        num  <= NUM_W'(high) * NUM_W'(PER_MILLE);
        den  <= NUM_W'(period) << (QUOT_W - 1);
        quot <= '0;
        qcnt <= QLAST;
      end
      SQ_DIV: begin
        if (!alu_borrow) num <= alu_diff;
        den  <= den >> 1;
        quot <= quot_step;
        qcnt <= qcnt - 1'b1;
        if (qcnt == '0) begin
          res <= '{status: STS_DONE, duty_mode: 1'b1,
                   value: STAMP_W'((quot_step > QMAX) ? QMAX : quot_step)};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/ecpdm_chk.sv -----
module ecpdm_chk
  import ecpdm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a held result must not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item at a time: input closes after each accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input still open after accept");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != STS_DONE |-> m_tdata == '0)
    else $error("non-zero value on timeout or error");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == STS_DONE && m_tuser[2] |-> m_tdata <= 32'(PER_MILLE))
    else $error("duty above 1000 per mille");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind edge_capture_period_duty_meter_core ecpdm_chk u_chk (.*);
